[rtl/sstf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstf_pkg
// shared widths, defaults and the search word passed along the cell row
// ----------------------------------------------------------------------------
package sstf_pkg;

  localparam int CYL_W            = 16;
  localparam int TOT_W            = 22;
  localparam int DEF_MAX_REQUESTS = 64;

  typedef struct packed {
    logic             vld;
    logic [CYL_W-1:0] seek;
    logic [CYL_W-1:0] cyl;
  } tok_t;

endpackage

[rtl/sstf_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstf_cell
// one request slot: holds a cylinder and its pending bit, compares its seek
// distance to the best word from the previous cell and forwards the winner
// ----------------------------------------------------------------------------
module sstf_cell #(
  parameter int CELL_IDX = 0,
  parameter int IDX_W    = 6
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      wr_en,
  input  logic [sstf_pkg::CYL_W-1:0] wr_cyl,
  input  logic [sstf_pkg::CYL_W-1:0] head,
  input  logic                      pick_en,
  input  logic [IDX_W-1:0]          pick_idx,
  input  sstf_pkg::tok_t            tok_in,
  input  logic [IDX_W-1:0]          idx_in,
  output sstf_pkg::tok_t            tok_out,
  output logic [IDX_W-1:0]          idx_out
);

  logic [sstf_pkg::CYL_W-1:0] cyl_r;
  logic                       pend_r;
  logic                       pend_nxt;
  logic [sstf_pkg::CYL_W-1:0] seek_d;
  logic                       take;
  sstf_pkg::tok_t             tok_r;
  sstf_pkg::tok_t             tok_nxt;
  logic [IDX_W-1:0]           idx_r;
  logic [IDX_W-1:0]           idx_nxt;

  assign seek_d = (cyl_r > head) ? (cyl_r - head) : (head - cyl_r);
  assign take   = pend_r && (!tok_in.vld || (seek_d < tok_in.seek));

  always_comb begin
    pend_nxt = pend_r;
    if (pick_en && (pick_idx == IDX_W'(CELL_IDX))) begin
      pend_nxt = 1'b0;
    end
    if (wr_en) begin
      pend_nxt = 1'b1;
    end
    if (take) begin
      tok_nxt.vld  = 1'b1;
      tok_nxt.seek = seek_d;
      tok_nxt.cyl  = cyl_r;
      idx_nxt      = IDX_W'(CELL_IDX);
    end else begin
      tok_nxt = tok_in;
      idx_nxt = idx_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      tok_r  <= '0;
    end else begin
      pend_r <= pend_nxt;
      tok_r  <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cyl_r <= wr_cyl;
    end
    idx_r <= idx_nxt;
  end

  assign tok_out = tok_r;
  assign idx_out = idx_r;

endmodule

[rtl/sstf_disk_scheduler_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstf_disk_scheduler_top
// shortest seek time first scheduler built on a row of request cells
// operation: a load is written into the next free cell; a start with no requests
//   gives its empty word in the cycle after; otherwise each pick waits for the
//   best-distance word to walk the whole cell row once, and a held output delays it
// input stall: a start with n requests holds the input until all n are picked
// reset: synchronous active-low rst_n empties the store and clears overflow
// ----------------------------------------------------------------------------
module sstf_disk_scheduler_top #(
  parameter int MAX_REQUESTS = sstf_pkg::DEF_MAX_REQUESTS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_kind,
  input  logic [sstf_pkg::CYL_W-1:0]  in_cylinder,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [sstf_pkg::CYL_W-1:0]  out_served_cylinder,
  output logic [sstf_pkg::CYL_W-1:0]  out_seek_distance,
  output logic [sstf_pkg::TOT_W-1:0]  out_total_movement,
  output logic                        out_last,
  output logic                        out_empty_res,
  output logic                        out_overflow
);

  localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CNT_W = $clog2(MAX_REQUESTS + 1);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_SEARCH = 1'b1;

  logic                       state_r, state_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       ovf_r, ovf_nxt;
  logic [sstf_pkg::CYL_W-1:0] head_r, head_nxt;
  logic [sstf_pkg::TOT_W-1:0] total_r, total_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [sstf_pkg::CYL_W-1:0] out_cyl_r, out_cyl_nxt;
  logic [sstf_pkg::CYL_W-1:0] out_dist_r, out_dist_nxt;
  logic [sstf_pkg::TOT_W-1:0] out_tot_r, out_tot_nxt;
  logic                       out_last_r, out_last_nxt;
  logic                       out_empty_r, out_empty_nxt;
  logic                       out_ovf_r, out_ovf_nxt;

  logic in_acc;
  logic out_free;
  logic load;
  logic search_done;
  logic pick_en;

  sstf_pkg::tok_t   tok [MAX_REQUESTS+1];
  logic [IDX_W-1:0] idx [MAX_REQUESTS+1];

  assign tok[0] = '0;
  assign idx[0] = '0;

  assign out_free    = !out_valid_r || !out_stall;
  assign in_stall    = (state_r != ST_IDLE) || !out_free;
  assign in_acc      = in_valid && !in_stall;
  assign load        = in_acc && !in_kind && (count_r != CNT_W'(MAX_REQUESTS));
  assign search_done = (state_r == ST_SEARCH) && (cnt_r == CNT_W'(MAX_REQUESTS));
  assign pick_en     = search_done && out_free;

  genvar g;
  generate
    for (g = 0; g < MAX_REQUESTS; g++) begin : g_cell
      sstf_cell #(
        .CELL_IDX (g),
        .IDX_W    (IDX_W)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (load && (count_r == CNT_W'(g))),
        .wr_cyl   (in_cylinder),
        .head     (head_r),
        .pick_en  (pick_en),
        .pick_idx (idx[MAX_REQUESTS]),
        .tok_in   (tok[g]),
        .idx_in   (idx[g]),
        .tok_out  (tok[g+1]),
        .idx_out  (idx[g+1])
      );
    end
  endgenerate

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    head_nxt      = head_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_cyl_nxt   = out_cyl_r;
    out_dist_nxt  = out_dist_r;
    out_tot_nxt   = out_tot_r;
    out_last_nxt  = out_last_r;
    out_empty_nxt = out_empty_r;
    out_ovf_nxt   = out_ovf_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc && !in_kind) begin
          if (count_r != CNT_W'(MAX_REQUESTS)) begin
            count_nxt = count_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end else if (in_acc) begin
          if (count_r == '0) begin
            out_valid_nxt = 1'b1;
            out_cyl_nxt   = '0;
            out_dist_nxt  = '0;
            out_tot_nxt   = '0;
            out_last_nxt  = 1'b1;
            out_empty_nxt = 1'b1;
            out_ovf_nxt   = ovf_r;
            ovf_nxt       = 1'b0;
          end else begin
            state_nxt = ST_SEARCH;
            head_nxt  = in_cylinder;
            total_nxt = '0;
            cnt_nxt   = '0;
          end
        end
      end
      ST_SEARCH: begin
        if (!search_done) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end else if (pick_en) begin
          out_valid_nxt = 1'b1;
          out_cyl_nxt   = tok[MAX_REQUESTS].cyl;
          out_dist_nxt  = tok[MAX_REQUESTS].seek;
          out_tot_nxt   = total_r + sstf_pkg::TOT_W'(tok[MAX_REQUESTS].seek);
          out_last_nxt  = (count_r == CNT_W'(1));
          out_empty_nxt = 1'b0;
          out_ovf_nxt   = ovf_r;
          total_nxt     = total_r + sstf_pkg::TOT_W'(tok[MAX_REQUESTS].seek);
          head_nxt      = tok[MAX_REQUESTS].cyl;
          count_nxt     = count_r - CNT_W'(1);
          cnt_nxt       = '0;
          if (count_r == CNT_W'(1)) begin
            state_nxt = ST_IDLE;
            ovf_nxt   = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r      <= head_nxt;
    total_r     <= total_nxt;
    out_cyl_r   <= out_cyl_nxt;
    out_dist_r  <= out_dist_nxt;
    out_tot_r   <= out_tot_nxt;
    out_last_r  <= out_last_nxt;
    out_empty_r <= out_empty_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_served_cylinder = out_cyl_r;
  assign out_seek_distance   = out_dist_r;
  assign out_total_movement  = out_tot_r;
  assign out_last            = out_last_r;
  assign out_empty_res       = out_empty_r;
  assign out_overflow        = out_ovf_r;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_REQUESTS))
    else $error("request count beyond capacity");

  a_search_finds: assert property (@(posedge clk) disable iff (!rst_n)
    search_done |-> tok[MAX_REQUESTS].vld)
    else $error("search ended with no pending request");

  a_last_pick_ends: assert property (@(posedge clk) disable iff (!rst_n)
    pick_en && (count_r == CNT_W'(1)) |=> (count_r == '0) && (state_r == ST_IDLE)
      && !ovf_r)
    else $error("batch did not close after last pick");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_empty_r |-> out_last_r)
    else $error("empty word not flagged last");
`endif

endmodule
